>>> sv/packed_nibble_event_store_wear_core_macros.svh
// assertion helpers used by the checker file
`ifndef PACKED_NIBBLE_EVENT_STORE_WEAR_CORE_MACROS_SVH
`define PACKED_NIBBLE_EVENT_STORE_WEAR_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define PNESW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, disabled while reset is held
`define PNESW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

>>> sv/pnesw_pkg.sv
package pnesw_pkg;

    localparam int MODE_W  = 2;
    localparam int SLOT_W  = 9;
    localparam int NIB_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 8;
    localparam int THR_W   = 8;
    localparam int IDX_W   = SLOT_W - 1;
    localparam int ENTRY_W = CNT_W + BYTE_W;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(10);
    localparam logic [NIB_W-1:0] NIB_MASK  = NIB_W'(4'hF);

    // operation codes carried by the mode field
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COUNT = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic clr;      // write zero at the clear address and step it
        logic capture;  // take the input word and issue the store read
        logic load;     // commit the update and load the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done; // clear address is on the last entry
    } t_sts;

endpackage

>>> sv/pnesw_ram.sv
module pnesw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                 i_wr_data,
    input  logic                             i_rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/pnesw_ctrl.sv
module pnesw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  pnesw_pkg::t_sts i_sts,
    output pnesw_pkg::t_cmd o_cmd
);
    import pnesw_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_CALC  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // output register can take a new word this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // next state and commands
    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && i_out_stall;
        o_cmd.clr     = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.load    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_CALC;
                end
            end
            ST_CALC: begin
                if (out_free) begin
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> sv/pnesw_dp.sv
module pnesw_dp #(
    parameter int STORE_BYTES = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pnesw_pkg::t_cmd              i_cmd,
    output pnesw_pkg::t_sts              o_sts,
    input  logic [pnesw_pkg::MODE_W-1:0] i_mode,
    input  logic [pnesw_pkg::SLOT_W-1:0] i_slot_index,
    input  logic [pnesw_pkg::NIB_W-1:0]  i_event_value,
    input  logic                         i_cfg_wr,
    input  logic [pnesw_pkg::THR_W-1:0]  i_cfg_data,
    output logic [pnesw_pkg::NIB_W-1:0]  o_read_value,
    output logic                         o_wear_alert,
    output logic [pnesw_pkg::IDX_W-1:0]  o_worn_byte
);
    import pnesw_pkg::*;

    // only bytes reachable by a slot index are stored
    localparam int REACH = 1 << IDX_W;
    localparam int DEPTH = (STORE_BYTES < REACH) ? STORE_BYTES : REACH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W:0]  IDX_LIMIT = (IDX_W+1)'(DEPTH);
    localparam logic [AW-1:0]   LAST_ADDR = AW'(DEPTH - 1);

    logic [THR_W-1:0]   r_thr;
    logic [AW-1:0]      r_clr_addr;
    logic [MODE_W-1:0]  r_mode;
    logic [IDX_W-1:0]   r_byte;
    logic               r_odd;
    logic [NIB_W-1:0]   r_event;
    logic [NIB_W-1:0]   r_read_value;
    logic               r_wear_alert;
    logic [IDX_W-1:0]   r_worn_byte;

    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] wr_data;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   in_byte;
    logic [BYTE_W-1:0]  old_byte;
    logic [CNT_W-1:0]   old_cnt;
    logic [BYTE_W-1:0]  new_byte;
    logic [CNT_W-1:0]   inc_cnt;
    logic [CNT_W-1:0]   new_cnt;
    logic [NIB_W-1:0]   nib;
    logic               in_range;
    logic               is_write;
    logic               alert;

    assign in_byte  = i_slot_index[SLOT_W-1:1];
    assign old_byte = rd_data[BYTE_W-1:0];
    assign old_cnt  = rd_data[ENTRY_W-1:BYTE_W];
    assign in_range = ({1'b0, r_byte} < IDX_LIMIT);

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_wr) begin
            r_thr <= i_cfg_data;
        end
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr && (r_clr_addr != LAST_ADDR)) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    assign o_sts.clr_done = (r_clr_addr == LAST_ADDR);

    // capture of the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_byte  <= in_byte;
            r_odd   <= i_slot_index[0];
            r_event <= i_event_value;
        end
    end

    // nibble select and merge: even slot in the high nibble
    always_comb begin
        nib      = r_odd ? old_byte[NIB_W-1:0] : old_byte[BYTE_W-1:NIB_W];
        new_byte = r_odd ? {old_byte[BYTE_W-1:NIB_W], r_event}
                         : {r_event, old_byte[NIB_W-1:0]};
        inc_cnt  = old_cnt + CNT_W'(1);
        is_write = (r_mode inside {MODE_WRITE, MODE_COUNT}) && in_range;
        alert    = (r_mode == MODE_COUNT) && in_range && (inc_cnt > r_thr);
        case (r_mode)
            MODE_COUNT: new_cnt = alert ? '0 : inc_cnt;
            default:    new_cnt = old_cnt;
        endcase
    end

    // store write port: clearing pass or read-modify-write commit
    always_comb begin
        if (i_cmd.clr) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = i_cmd.load && is_write;
            wr_addr = r_byte[AW-1:0];
            wr_data = {new_cnt, new_byte};
        end
    end

    pnesw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.capture),
        .i_rd_addr (in_byte[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_read_value <= ((r_mode == MODE_READ) && in_range) ? (nib & NIB_MASK) : '0;
            r_wear_alert <= alert;
            r_worn_byte  <= alert ? r_byte : '0;
        end
    end

    assign o_read_value = r_read_value;
    assign o_wear_alert = r_wear_alert;
    assign o_worn_byte  = r_worn_byte;

endmodule

>>> sv/packed_nibble_event_store_wear_core.sv
// Packed nibble event store with per-byte write wear counter.
// Input channel (i_in_valid / o_in_stall) carries one word: mode, slot index
// and event code. Mode read returns the slot's code, plain write stores it,
// counted write stores it and bumps the byte's wear counter; when the counter
// passes the threshold the result word flags a wear alert with the byte index
// and the counter restarts at zero. Unused mode changes nothing.
// Output channel (o_out_valid / i_out_stall) returns exactly one word per
// input word, in order.
// A word accepted at the input is captured and its store read issued; its
// result is loaded into the output register once that register is free.
// No new word is taken before then: the store read of a byte and its counter,
// then the modify and write back through the single write port.
// The output register holds a result while the receiver stalls; the next word
// is accepted meanwhile and its result waits in the store stage until the
// output register frees up.
// Configuration: i_cfg_valid / o_cfg_ready writes the wear threshold (reset 10).
// Reset: synchronous, active low. After reset a clearing pass zeroes one store
// entry per cycle, all min(STORE_BYTES, 256) entries, with the input held stalled.
module packed_nibble_event_store_wear_core #(
    parameter int STORE_BYTES = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [pnesw_pkg::MODE_W-1:0] i_mode,
    input  logic [pnesw_pkg::SLOT_W-1:0] i_slot_index,
    input  logic [pnesw_pkg::NIB_W-1:0]  i_event_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [pnesw_pkg::NIB_W-1:0]  o_read_value,
    output logic                         o_wear_alert,
    output logic [pnesw_pkg::IDX_W-1:0]  o_worn_byte,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pnesw_pkg::THR_W-1:0]  i_cfg_data
);
    import pnesw_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // threshold register is always writable
    assign o_cfg_ready = 1'b1;

    pnesw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pnesw_dp #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_mode        (i_mode),
        .i_slot_index  (i_slot_index),
        .i_event_value (i_event_value),
        .i_cfg_wr      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_read_value  (o_read_value),
        .o_wear_alert  (o_wear_alert),
        .o_worn_byte   (o_worn_byte)
    );

endmodule

>>> sv/pnesw_checker.sv
`include "packed_nibble_event_store_wear_core_macros.svh"

module pnesw_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic [pnesw_pkg::MODE_W-1:0] i_mode,
    input logic [pnesw_pkg::SLOT_W-1:0] i_slot_index,
    input logic [pnesw_pkg::NIB_W-1:0]  i_event_value,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [pnesw_pkg::NIB_W-1:0]  o_read_value,
    input logic                         o_wear_alert,
    input logic [pnesw_pkg::IDX_W-1:0]  o_worn_byte,
    input logic                         i_cfg_valid,
    input logic                         o_cfg_ready,
    input logic [pnesw_pkg::THR_W-1:0]  i_cfg_data
);

    // a stalled result word holds
    `PNESW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_read_value) && $stable(o_wear_alert) && $stable(o_worn_byte))

    // one word in flight: accepting closes the input for the next cycle
    `PNESW_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // a worn byte index only comes with an alert
    `PNESW_ASSERT_NOW(a_worn_needs_alert, i_clk, i_rst_n, o_out_valid && !o_wear_alert, o_worn_byte == '0)

    // an alert only comes from a write, which reads back zero
    `PNESW_ASSERT_NOW(a_alert_no_read, i_clk, i_rst_n, o_out_valid && o_wear_alert, o_read_value == '0)

endmodule

bind packed_nibble_event_store_wear_core pnesw_checker u_pnesw_checker (.*);
